FILE: rtl/core/hcbd_pkg.sv
// Shared types and constants for the HTTP chunked body decoder.
`default_nettype none

package hcbd_pkg;

	// Framing characters.
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// Result kinds.
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Register map: bit 2 of the byte address selects the register slot.
	localparam logic REG_PASSTHROUGH = 1'b0;
	localparam int   PADDR_W         = 3;

	// Result queue geometry.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Decoder phases.
	typedef enum logic [2:0] {
		PH_SIZE   = 3'd0,
		PH_HDR_CR = 3'd1,
		PH_HDR_LF = 3'd2,
		PH_DATA   = 3'd3,
		PH_TRL_CR = 3'd4,
		PH_TRL_LF = 3'd5
	} phase_t;

	// One input beat.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_final;
	} in_t;

	// One result beat.
	typedef struct packed {
		logic        kind;
		logic [7:0]  out_byte;
		logic [31:0] decoded_length;
	} out_t;

	// Results produced by one decoded byte, handed to the result queue.
	typedef struct packed {
		logic [1:0] num;
		out_t       res0;
		out_t       res1;
	} push_t;

	// Queue fill level reported back to the top level.
	typedef struct packed {
		logic [QCNT_W-1:0] count;
	} qstat_t;

endpackage

`default_nettype wire

FILE: rtl/core/hcbd_regs.sv
// Configuration register file with an APB-style access port.
`default_nettype none

module hcbd_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [hcbd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output logic                             passthrough
);

	logic passthrough_q;
	logic wr_en;

	// A write lands in the access phase.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passthrough_q <= 1'b0;
		end else if (wr_en && (paddr[2] == hcbd_pkg::REG_PASSTHROUGH)) begin
			passthrough_q <= pwdata[0];
		end
	end

	// Read back the selected register.
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == hcbd_pkg::REG_PASSTHROUGH) begin
			prdata = {31'd0, passthrough_q};
		end
	end

	assign passthrough = passthrough_q;

endmodule

`default_nettype wire

FILE: rtl/core/hcbd_core.sv
// Chunk framing state machine: turns one body byte into up to two results.
`default_nettype none

module hcbd_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           passthrough,
	input  wire logic           adv,
	input  wire hcbd_pkg::in_t  item,
	output hcbd_pkg::push_t     push
);

	hcbd_pkg::phase_t phase_q, phase_d, ph, work_ph;
	logic [31:0] size_q, size_d;
	logic [31:0] left_q, left_d, left_use, left_dec;
	logic [31:0] count_q, count_d;
	logic        fin_q, fin_d;
	logic        drop, emit, term, end_res;
	logic [7:0]  b;
	logic        is_hex;
	logic [3:0]  hex_val;
	hcbd_pkg::out_t data_res, end_res_v;

	assign b = item.in_byte;

	// Hex digit decode in either letter case.
	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			hex_val = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			hex_val = 4'(b - 8'h61 + 8'd10);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			hex_val = 4'(b - 8'h41 + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
	end

	// Next state and results for the byte in the input register.
	always_comb begin
		phase_d  = phase_q;
		size_d   = size_q;
		left_d   = left_q;
		count_d  = count_q;
		fin_d    = fin_q;
		drop     = 1'b0;
		emit     = 1'b0;
		term     = 1'b0;
		left_use = left_q;
		left_dec = 32'd0;
		ph       = phase_q;
		work_ph  = phase_q;

		unique case (phase_q)
			hcbd_pkg::PH_SIZE, hcbd_pkg::PH_HDR_CR, hcbd_pkg::PH_HDR_LF,
			hcbd_pkg::PH_DATA, hcbd_pkg::PH_TRL_CR, hcbd_pkg::PH_TRL_LF: ph = phase_q;
			default: ph = hcbd_pkg::PH_SIZE;
		endcase
		work_ph = ph;

		if (!fin_q) begin
			if (passthrough) begin
				emit = 1'b1;
			end else begin
				// Optional CR and LF slots.
				unique case (ph)
					hcbd_pkg::PH_HDR_CR: begin
						if (b == hcbd_pkg::CH_CR) begin
							phase_d = hcbd_pkg::PH_HDR_LF;
							drop    = 1'b1;
						end else begin
							left_use = size_q;
							left_d   = size_q;
							phase_d  = hcbd_pkg::PH_DATA;
							if (b == hcbd_pkg::CH_LF) drop = 1'b1;
							else work_ph = hcbd_pkg::PH_DATA;
						end
					end
					hcbd_pkg::PH_HDR_LF: begin
						left_use = size_q;
						left_d   = size_q;
						phase_d  = hcbd_pkg::PH_DATA;
						if (b == hcbd_pkg::CH_LF) drop = 1'b1;
						else work_ph = hcbd_pkg::PH_DATA;
					end
					hcbd_pkg::PH_TRL_CR: begin
						if (b == hcbd_pkg::CH_CR) begin
							phase_d = hcbd_pkg::PH_TRL_LF;
							drop    = 1'b1;
						end else begin
							phase_d = hcbd_pkg::PH_SIZE;
							if (b == hcbd_pkg::CH_LF) drop = 1'b1;
							else work_ph = hcbd_pkg::PH_SIZE;
						end
					end
					hcbd_pkg::PH_TRL_LF: begin
						phase_d = hcbd_pkg::PH_SIZE;
						if (b == hcbd_pkg::CH_LF) drop = 1'b1;
						else work_ph = hcbd_pkg::PH_SIZE;
					end
					default: begin
						work_ph = ph;
					end
				endcase

				if (!drop) begin
					if (work_ph == hcbd_pkg::PH_DATA) begin
						// Data byte: count down the chunk.
						emit     = 1'b1;
						left_dec = (left_use != 32'd0) ? left_use - 32'd1 : 32'd0;
						left_d   = left_dec;
						if (left_dec == 32'd0) begin
							size_d  = 32'd0;
							phase_d = hcbd_pkg::PH_TRL_CR;
						end else begin
							phase_d = hcbd_pkg::PH_DATA;
						end
					end else begin
						// Size field: collect digits, a non-digit closes it.
						phase_d = hcbd_pkg::PH_SIZE;
						if (is_hex) begin
							size_d = {size_q[27:0], hex_val};
						end else if (size_q == 32'd0) begin
							term = 1'b1;
						end else if (b == hcbd_pkg::CH_CR) begin
							phase_d = hcbd_pkg::PH_HDR_LF;
						end else begin
							phase_d = hcbd_pkg::PH_HDR_CR;
						end
					end
				end
			end

			if (emit && count_q != 32'hFFFF_FFFF) begin
				count_d = count_q + 32'd1;
			end
			if (term) begin
				fin_d = 1'b1;
			end
		end

		end_res = !fin_q && (term || (item.is_final && !fin_d));
	end

	// Assemble the result beats.
	always_comb begin
		data_res.kind           = hcbd_pkg::KIND_DATA;
		data_res.out_byte       = b;
		data_res.decoded_length = count_d;
		end_res_v.kind           = hcbd_pkg::KIND_END;
		end_res_v.out_byte       = 8'd0;
		end_res_v.decoded_length = count_d;

		push.num  = 2'd0;
		push.res0 = data_res;
		push.res1 = end_res_v;
		if (adv) begin
			if (emit && end_res) begin
				push.num = 2'd2;
			end else if (emit) begin
				push.num = 2'd1;
			end else if (end_res) begin
				push.num  = 2'd1;
				push.res0 = end_res_v;
			end
		end
	end

	// Body state; a final byte returns everything to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcbd_pkg::PH_SIZE;
			size_q  <= 32'd0;
			left_q  <= 32'd0;
			count_q <= 32'd0;
			fin_q   <= 1'b0;
		end else if (adv) begin
			if (item.is_final) begin
				phase_q <= hcbd_pkg::PH_SIZE;
				size_q  <= 32'd0;
				left_q  <= 32'd0;
				count_q <= 32'd0;
				fin_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				size_q  <= size_d;
				left_q  <= left_d;
				count_q <= count_d;
				fin_q   <= fin_d;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/hcbd_queue.sv
// Result queue: per cycle up to two in, one out unless stalled.
`default_nettype none

module hcbd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire hcbd_pkg::push_t push,
	input  wire logic            pop_stall,
	output logic                 out_valid,
	output hcbd_pkg::out_t       out_data,
	output hcbd_pkg::qstat_t     stat
);

	hcbd_pkg::out_t mem [hcbd_pkg::QUEUE_DEPTH];
	logic [hcbd_pkg::QPTR_W-1:0] wr_q, rd_q, wr_next;
	logic [hcbd_pkg::QCNT_W-1:0] count_q;
	logic                         pop;

	assign out_valid  = (count_q != '0);
	assign pop        = out_valid && !pop_stall;
	assign wr_next    = wr_q + hcbd_pkg::QPTR_W'(1);
	assign out_data   = mem[rd_q];
	assign stat.count = count_q;

	// Storage for queued beats.
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem[wr_q] <= push.res0;
		end
		if (push.num == 2'd2) begin
			mem[wr_next] <= push.res1;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + hcbd_pkg::QPTR_W'(push.num);
			if (pop) begin
				rd_q <= rd_q + hcbd_pkg::QPTR_W'(1);
			end
			count_q <= count_q + hcbd_pkg::QCNT_W'(push.num)
				- hcbd_pkg::QCNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/http_chunked_body_decoder.sv
// A byte waits in the input register, then its results are written into the result
// queue, whose head drives the output. Throughput: one byte per cycle while the
// four-entry queue has at least two free slots; input stalls when it has fewer.
// Reset: arst_n clears the decoder state, passthrough, input register and queue
// at once; no clearing pass is needed.
`default_nettype none

module http_chunked_body_decoder (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire hcbd_pkg::in_t                in_data,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output hcbd_pkg::out_t                    out_data,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [hcbd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);

	logic             passthrough;
	logic             valid_s1;
	hcbd_pkg::in_t    item_s1;
	logic             adv;
	logic             load;
	hcbd_pkg::push_t  push;
	hcbd_pkg::qstat_t qstat;

	hcbd_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.passthrough (passthrough)
	);

	// The held byte moves on when the queue has room for two beats.
	assign adv      = valid_s1 &&
		(qstat.count <= hcbd_pkg::QCNT_W'(hcbd_pkg::QUEUE_DEPTH - 2));
	assign in_stall = valid_s1 && !adv;
	assign load     = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_data;
		end
	end

	hcbd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.passthrough (passthrough),
		.adv         (adv),
		.item        (item_s1),
		.push        (push)
	);

	hcbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.stat      (qstat)
	);

`ifndef SYNTHESIS
	// The queue never holds more beats than it has slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= hcbd_pkg::QCNT_W'(hcbd_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");

	// Input is held back only while a byte waits in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// Results are produced only for a byte that moves on.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push.num != 2'd0) |-> adv)
		else $error("results pushed without a decoded byte");

	// With no push and no delivery the fill level holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push.num == 2'd0 && !(out_valid && !out_stall)) |=> $stable(qstat.count))
		else $error("queue level changed without traffic");
`endif

endmodule

`default_nettype wire

FILE: bench/hcbd_checker.sv
// Checker for the chunked body decoder: tracks the register, predicts result beats, compares them.
module hcbd_checker
	import hcbd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  in_t                 in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  out_t                out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  pending,
	output int                  in_beats,
	output int                  out_beats,
	output int                  end_beats
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          MAX_REPORTS = 10;
	localparam logic [7:0]  ASCII_0     = 8'h30;
	localparam logic [7:0]  ASCII_9     = 8'h39;
	localparam logic [7:0]  ASCII_LO_A  = 8'h61;
	localparam logic [7:0]  ASCII_LO_F  = 8'h66;
	localparam logic [7:0]  ASCII_UP_A  = 8'h41;
	localparam logic [7:0]  ASCII_UP_F  = 8'h46;
	localparam int          HEX_TEN     = 10;

	// Shadow of the passthrough register and of the framing state.
	logic        pt_mode;
	logic [2:0]  dec_phase;
	logic [31:0] size_acc;
	logic [31:0] chunk_left;
	logic [31:0] emit_cnt;
	logic        body_done;

	// Result beats predicted but not yet seen on the output channel.
	out_t expected_beats[$];

	function automatic int hex_nibble(logic [7:0] b);
		if (b >= ASCII_0 && b <= ASCII_9) return int'(b - ASCII_0);
		if (b >= ASCII_LO_A && b <= ASCII_LO_F) return int'(b - ASCII_LO_A) + HEX_TEN;
		if (b >= ASCII_UP_A && b <= ASCII_UP_F) return int'(b - ASCII_UP_A) + HEX_TEN;
		return -1;
	endfunction

	function automatic void push_result(logic kind, logic [7:0] b);
		out_t r;
		r.kind = kind;
		r.out_byte = b;
		r.decoded_length = emit_cnt;
		expected_beats.push_back(r);
	endfunction

	// A data beat bumps the decoded length, which saturates.
	function automatic void emit_data(logic [7:0] b);
		if (emit_cnt != 32'hFFFF_FFFF) emit_cnt = emit_cnt + 32'd1;
		push_result(KIND_DATA, b);
	endfunction

	function automatic void clear_body();
		dec_phase = PH_SIZE;
		size_acc = '0;
		chunk_left = '0;
		emit_cnt = '0;
		body_done = 1'b0;
	endfunction

	// Advances the framing state by one byte; returns 1 when the byte ends the body.
	function automatic bit decode_step(logic [7:0] b);
		logic [2:0] ph;
		int d;
		ph = dec_phase;
		if (ph > PH_TRL_LF) ph = PH_SIZE;

		// CR and LF slots: a byte that is neither falls through to data or size.
		case (ph)
			PH_HDR_CR: begin
				if (b == CH_CR) begin
					dec_phase = PH_HDR_LF;
					return 1'b0;
				end
				chunk_left = size_acc;
				dec_phase = PH_DATA;
				if (b == CH_LF) return 1'b0;
				ph = PH_DATA;
			end
			PH_HDR_LF: begin
				chunk_left = size_acc;
				dec_phase = PH_DATA;
				if (b == CH_LF) return 1'b0;
				ph = PH_DATA;
			end
			PH_TRL_CR: begin
				if (b == CH_CR) begin
					dec_phase = PH_TRL_LF;
					return 1'b0;
				end
				dec_phase = PH_SIZE;
				if (b == CH_LF) return 1'b0;
				ph = PH_SIZE;
			end
			PH_TRL_LF: begin
				dec_phase = PH_SIZE;
				if (b == CH_LF) return 1'b0;
				ph = PH_SIZE;
			end
			default: ;
		endcase

		// Chunk payload.
		if (ph == PH_DATA) begin
			emit_data(b);
			if (chunk_left != 0) chunk_left = chunk_left - 32'd1;
			if (chunk_left == 0) begin
				size_acc = '0;
				dec_phase = PH_TRL_CR;
			end else begin
				dec_phase = PH_DATA;
			end
			return 1'b0;
		end

		// Size field: hex digits shift in, anything else closes the field.
		dec_phase = PH_SIZE;
		d = hex_nibble(b);
		if (d >= 0) begin
			size_acc = {size_acc[27:0], d[3:0]};
			return 1'b0;
		end
		if (size_acc == 0) return 1'b1;
		dec_phase = (b == CH_CR) ? PH_HDR_LF : PH_HDR_CR;
		return 1'b0;
	endfunction

	function automatic void predict_beat(in_t beat);
		bit term;
		if (!body_done) begin
			if (pt_mode) begin
				emit_data(beat.in_byte);
			end else begin
				term = decode_step(beat.in_byte);
				if (term) begin
					body_done = 1'b1;
					push_result(KIND_END, 8'h00);
				end
			end
			if (beat.is_final && !body_done) push_result(KIND_END, 8'h00);
		end
		if (beat.is_final) clear_body();
	endfunction

	// Register writes, input prediction and output comparison, all sampled at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		out_t got;
		out_t want;
		if (!arst_n) begin
			pt_mode = 1'b0;
			clear_body();
			expected_beats.delete();
			fail_count = 0;
			pending = 0;
			in_beats = 0;
			out_beats = 0;
			end_beats = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_PASSTHROUGH) begin
				pt_mode = pwdata[0];
			end

			if (in_valid && !in_stall) begin
				in_beats++;
				predict_beat(in_data);
			end

			if (out_valid && !out_stall) begin
				got = out_data;
				out_beats++;
				if (got.kind == KIND_END) end_beats++;
				if (expected_beats.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("Unexpected result beat at %0t: kind=%0d byte=%02h len=%0d",
							$time, got.kind, got.out_byte, got.decoded_length);
					end
				end else begin
					want = expected_beats.pop_front();
					if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
						got.decoded_length !== want.decoded_length) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("Mismatch at %0t: expected kind=%0d byte=%02h len=%0d, got kind=%0d byte=%02h len=%0d",
								$time, want.kind, want.out_byte, want.decoded_length,
								got.kind, got.out_byte, got.decoded_length);
						end
					end
				end
			end

			pending = expected_beats.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
// Top of the chunked body decoder testbench: clock, reset, stimulus, stalls and verdict.
module tb_top;
	import hcbd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RESET_CYCLES   = 11;
	localparam int          SETTLE_CYCLES  = 6;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          RANDOM_DECODE  = 290;
	localparam int          RANDOM_COPY    = 60;
	localparam int          RANDOM_TAIL    = 90;
	localparam logic [PADDR_W-1:0] PT_ADDR = PADDR_W'({REG_PASSTHROUGH, 2'b00});
	localparam logic [7:0]  ASCII_0        = 8'h30;
	localparam logic [7:0]  ASCII_LO_A     = 8'h61;
	localparam logic [7:0]  ASCII_UP_A     = 8'h41;
	localparam logic [7:0]  ASCII_SEMI     = 8'h3B;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	in_t                 in_data;
	logic                out_valid;
	logic                out_stall;
	out_t                out_data;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	int fail_count;
	int pending;
	int in_beats;
	int out_beats;
	int end_beats;

	// Set by the stimulus to ask the result side for one long hold-off.
	bit hold_req;

	// Input beats waiting to be offered.
	in_t byte_plan[$];

	http_chunked_body_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	hcbd_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending),
		.in_beats   (in_beats),
		.out_beats  (out_beats),
		.end_beats  (end_beats)
	);

	// 10 ns clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void add_beat(logic [7:0] b, logic fin);
		in_t beat;
		beat.in_byte = b;
		beat.is_final = fin;
		byte_plan.push_back(beat);
	endfunction

	function automatic void add_text(string s);
		for (int k = 0; k < s.len(); k++) add_beat(s[k], 1'b0);
	endfunction

	function automatic void add_crlf();
		add_beat(CH_CR, 1'b0);
		add_beat(CH_LF, 1'b0);
	endfunction

	// Hex digit in a random letter case.
	function automatic logic [7:0] hex_char(logic [3:0] nib);
		if (nib < 4'd10) return ASCII_0 + 8'(nib);
		if ($urandom_range(0, 1) == 0) return ASCII_LO_A + 8'(nib - 4'd10);
		return ASCII_UP_A + 8'(nib - 4'd10);
	endfunction

	// Size field; with wrap set an extra leading digit is shifted out past bit 31.
	function automatic void add_hex_size(int unsigned size, bit wrap);
		int nd;
		nd = 1;
		while (nd < 8 && (size >> (4 * nd)) != 0) nd++;
		if (wrap) begin
			add_beat(hex_char(4'($urandom_range(1, 15))), 1'b0);
			nd = 8;
		end else if ($urandom_range(0, 7) == 0) begin
			add_beat(ASCII_0, 1'b0);
		end
		for (int k = nd - 1; k >= 0; k--) add_beat(hex_char(4'(size >> (4 * k))), 1'b0);
	endfunction

	// Line ending after a size or after chunk data, mostly well formed.
	function automatic void add_line_end(bit header);
		int style;
		style = $urandom_range(0, 9);
		if (style < 6) begin
			add_crlf();
		end else if (style == 6) begin
			add_beat(CH_CR, 1'b0);
		end else if (style == 7) begin
			add_beat(CH_LF, 1'b0);
		end else if (style == 8 && header) begin
			add_beat(ASCII_SEMI, 1'b0);
			add_crlf();
		end
	endfunction

	function automatic void add_noise(int count, int final_odds);
		repeat (count) add_beat(8'($urandom_range(0, 255)), $urandom_range(0, final_odds) == 0);
	endfunction

	// One body: a few chunks with random payload, then a terminator or a truncation.
	function automatic void add_chunked_body();
		int n_chunks;
		int size;
		int style;
		n_chunks = $urandom_range(0, 3);
		for (int c = 0; c < n_chunks; c++) begin
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
			add_hex_size(size, $urandom_range(0, 15) == 0);
			add_line_end(1'b1);
			repeat (size) add_beat(8'($urandom_range(0, 255)), 1'b0);
			add_line_end(1'b0);
		end
		style = $urandom_range(0, 9);
		if (style < 6) begin
			add_hex_size(0, 1'b0);
			add_beat(CH_CR, 1'b0);
			add_beat(CH_LF, 1'b0);
			add_beat(CH_CR, 1'b0);
			add_beat(CH_LF, 1'b1);
		end else if (style < 8) begin
			add_beat(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			add_hex_size(0, 1'b0);
			add_beat(ASCII_SEMI, 1'b0);
			add_noise($urandom_range(0, 4), 100);
			add_beat(8'($urandom_range(0, 255)), 1'b1);
		end
	endfunction

	function automatic void plan_decode(int count);
		while (byte_plan.size() < count) begin
			if ($urandom_range(0, 9) == 0) add_noise($urandom_range(1, 6), 7);
			else add_chunked_body();
		end
	endfunction

	// Register write: setup cycle, then access cycle until pready.
	task automatic apb_write(logic [PADDR_W-1:0] addr, logic value);
		logic [31:0] word;
		word = $urandom;
		word[0] = value;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offers the planned beats in bursts with random gaps.
	task automatic send_plan();
		int burst;
		int gap;
		@(negedge clk);
		while (byte_plan.size() != 0) begin
			burst = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			while (burst > 0 && byte_plan.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= byte_plan[0];
				do @(posedge clk); while (in_stall);
				void'(byte_plan.pop_front());
				burst--;
				@(negedge clk);
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				in_data <= in_t'($urandom);
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	// Waits until every predicted beat has arrived and in-flight bytes have settled.
	task automatic wait_idle();
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: randomly chosen stall modes, plus one long hold-off.
	initial begin : result_stall_gen
		int mode;
		int mode_left;
		int hold_left;
		int phase_cnt;
		out_stall <= 1'b0;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		phase_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 60);
			end else begin
				mode_left--;
			end
			phase_cnt = (phase_cnt + 1) % 5;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= (phase_cnt < 2);
				endcase
			end
		end
	end

	// Ends the run when no beat moves on either channel for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
		$display("** http_chunked_body_decoder: FAILED **");
		$finish;
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		hold_req = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed decode: a small chunk, the terminator on CR, a final byte after it.
		apb_write(PT_ADDR, 1'b0);
		add_text("3");
		add_crlf();
		add_beat("x", 1'b0);
		add_beat(8'h00, 1'b0);
		add_beat(8'hFF, 1'b0);
		add_crlf();
		add_text("0");
		add_crlf();
		add_beat("Z", 1'b1);
		// Missing CR and LF after a header and after data, then a zero size ended by
		// a non-hex byte that is also final.
		add_text("1;q2");
		add_beat(CH_CR, 1'b0);
		add_text("ab");
		add_beat(CH_LF, 1'b0);
		add_text("0");
		add_beat("x", 1'b1);
		// A body left open so the mode can be switched in the middle of a chunk.
		add_text("2");
		add_beat(CH_LF, 1'b0);
		add_beat("k", 1'b0);
		send_plan();
		wait_idle();

		// Passthrough in the middle of the open body.
		apb_write(PT_ADDR, 1'b1);
		add_beat(8'hFF, 1'b0);
		add_beat(CH_CR, 1'b0);
		send_plan();
		wait_idle();

		// Back to decoding: the last data byte of the chunk is also final.
		apb_write(PT_ADDR, 1'b0);
		add_beat("m", 1'b1);
		send_plan();
		wait_idle();

		// Random chunked bodies with malformed framing mixed in.
		apb_write(PT_ADDR, 1'b0);
		plan_decode(RANDOM_DECODE);
		send_plan();
		wait_idle();

		// Random raw bytes copied unchanged.
		apb_write(PT_ADDR, 1'b1);
		add_noise(RANDOM_COPY, 9);
		add_beat(8'($urandom_range(0, 255)), 1'b1);
		send_plan();
		wait_idle();

		// Decoding again while the result side holds off long enough to fill the queue.
		apb_write(PT_ADDR, 1'b0);
		plan_decode(RANDOM_TAIL);
		hold_req = 1'b1;
		send_plan();
		wait_idle();

		$display("Run covered %0d input beats and %0d result beats, %0d of them end of body.",
			in_beats, out_beats, end_beats);
		$display("Decode and copy modes, broken framing, size wrap and a full result queue were hit.");
		if (fail_count == 0 && pending == 0) begin
			$display("** http_chunked_body_decoder: PASSED **");
		end else begin
			$display("** http_chunked_body_decoder: FAILED **");
		end
		$finish;
	end

endmodule
